FILE: rtl/fvc_pkg.sv
// Package with the word types, register map, constants and arithmetic helpers of the controller.
`timescale 1ns / 1ps
package fvc_pkg;

  localparam int DATA_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 14;
  localparam int DIV_BITS          = 12;

  localparam int XY_W = 35;
  localparam int Z_W  = 20;

  localparam logic signed [Z_W-1:0] PI_Q16        = 20'sd205887;
  localparam logic [16:0]            FWD_DEADBAND  = 17'd205;
  localparam logic [13:0]            REVERSE_NUM   = 14'd3277;
  localparam logic signed [21:0]     MIN_FWD       = 22'sd246;
  localparam logic [16:0]            TURN_DEADBAND = 17'd410;
  localparam logic [17:0]            LAT_DEADBAND  = 18'd123;
  localparam logic [17:0]            LAT_CUTOFF    = 18'd4096;
  localparam logic [11:0]            SLOW_MIN      = 12'd410;

  localparam logic signed [Z_W-1:0] ATAN_LOW [8] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
    20'sd4091,  20'sd2047,  20'sd1024,  20'sd512
  };

  typedef enum logic [2:0] {
    REG_FOLLOW_DISTANCE  = 3'd0,
    REG_FORWARD_GAIN     = 3'd1,
    REG_TURN_GAIN        = 3'd2,
    REG_LATERAL_GAIN     = 3'd3,
    REG_LIN_SPEED_LIMIT  = 3'd4,
    REG_MAX_TURN_RATE    = 3'd5,
    REG_STOP_DISTANCE    = 3'd6,
    REG_SLOW_DISTANCE    = 3'd7
  } fvc_reg_e;

  typedef struct packed {
    logic [14:0] follow_distance;
    logic [15:0] forward_gain;
    logic [15:0] turn_gain;
    logic [15:0] lateral_gain;
    logic [14:0] lin_speed_limit;
    logic [14:0] max_turn_rate;
    logic [14:0] stop_distance;
    logic [14:0] slow_distance;
  } fvc_cfg_t;

  typedef struct packed {
    logic signed [15:0] target_forward;
    logic signed [15:0] target_side;
    logic signed [15:0] left_clearance;
    logic signed [15:0] right_clearance;
    logic signed [15:0] repel_forward;
    logic signed [15:0] repel_side;
    logic        [14:0] obstacle_distance;
  } fvc_in_t;

  typedef struct packed {
    logic signed [15:0] speed_forward;
    logic signed [15:0] speed_side;
    logic signed [15:0] turn_rate;
  } fvc_out_t;

  // Word handed from cell to cell: CORDIC vector, divider state and the
  // forward and lateral terms riding alongside.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    logic [14:0]            rem;
    logic [DIV_BITS-1:0]    quo;
    logic [14:0]            dvs;
    logic signed [22:0]     fwd;
    logic signed [18:0]     side;
    logic                   stop;
    logic                   slow;
  } fvc_cell_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] a;
    if (i < 8) begin
      a = ATAN_LOW[i];
    end else if (i < 17) begin
      a = Z_W'(65536 >> i);
    end else begin
      a = '0;
    end
    return a;
  endfunction

  // Division by 2^n rounded to nearest, ties away from zero.
  function automatic logic signed [39:0] round_shift(input logic signed [39:0] v,
                                                     input int unsigned n);
    logic [39:0] m;
    logic [39:0] r;
    m = v[39] ? 40'(-v) : 40'(v);
    r = (m + (40'd1 << (n - 1))) >> n;
    return v[39] ? -$signed(r) : $signed(r);
  endfunction

endpackage

FILE: rtl/follow_velocity_controller_core.sv
// Top level of the follow velocity controller: register file, front, cell chain and back.
// Usage:
// One input word per sample carries target position, side clearances, repulsion and
// obstacle distance; one output word carries forward speed, lateral speed and turn rate.
// Both channels use valid/ready; a word moves when valid and ready are high together.
// Registers are written through cfg_we, cfg_index and cfg_data with no wait state; the
// user must write them only while no word is in flight, as the block does not enforce it.
// The datapath is a single pipeline that takes one word per cycle unless the output stalls.
// Its stages: four front stages, one cell per CORDIC step or quotient bit, two back stages.
// Each cell performs at most one CORDIC rotation and one divider bit; the larger of the two
// step counts sets the depth.
// When the receiver holds ready low while a word is shown, the whole pipeline freezes
// and in_ready drops; the shown word stays unchanged until taken.
// Reset empties the pipeline and returns every configuration register to its default value.
`timescale 1ns / 1ps
module follow_velocity_controller_core #(
  parameter int DATA_WIDTH    = fvc_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STAGES = fvc_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  fvc_pkg::fvc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fvc_pkg::fvc_out_t out_data
);
  import fvc_pkg::*;

  localparam int NCELL = (CORDIC_STAGES > DIV_BITS) ? CORDIC_STAGES : DIV_BITS;

  fvc_cfg_t  cfg;
  logic      en;
  logic      chain_valid [NCELL+1];
  fvc_cell_t chain_cell  [NCELL+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.follow_distance  <= 15'd1638;
      cfg.forward_gain     <= 16'd2048;
      cfg.turn_gain        <= 16'd4096;
      cfg.lateral_gain     <= 16'd4096;
      cfg.lin_speed_limit  <= 15'd4096;
      cfg.max_turn_rate    <= 15'd4096;
      cfg.stop_distance    <= 15'd819;
      cfg.slow_distance    <= 15'd1024;
    end else if (cfg_we) begin
      unique case (fvc_reg_e'(cfg_index))
        REG_FOLLOW_DISTANCE:  cfg.follow_distance  <= cfg_data[14:0];
        REG_FORWARD_GAIN:     cfg.forward_gain     <= cfg_data;
        REG_TURN_GAIN:        cfg.turn_gain        <= cfg_data;
        REG_LATERAL_GAIN:     cfg.lateral_gain     <= cfg_data;
        REG_LIN_SPEED_LIMIT:  cfg.lin_speed_limit  <= cfg_data[14:0];
        REG_MAX_TURN_RATE:    cfg.max_turn_rate    <= cfg_data[14:0];
        REG_STOP_DISTANCE:    cfg.stop_distance    <= cfg_data[14:0];
        REG_SLOW_DISTANCE:    cfg.slow_distance    <= cfg_data[14:0];
        default:              ;
      endcase
    end
  end

  fvc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .valid_o  (chain_valid[0]),
    .cell_o   (chain_cell[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    fvc_cell #(
      .IDX           (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (chain_valid[k]),
      .cell_i  (chain_cell[k]),
      .valid_o (chain_valid[k+1]),
      .cell_o  (chain_cell[k+1])
    );
  end

  fvc_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_i   (chain_valid[NCELL]),
    .cell_i    (chain_cell[NCELL]),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/fvc_front.sv
// Front stages: input capture, forward and lateral terms, CORDIC and divider set-up.
`timescale 1ns / 1ps
module fvc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  fvc_pkg::fvc_in_t  in_data,
  input  fvc_pkg::fvc_cfg_t cfg,
  output logic             valid_o,
  output fvc_pkg::fvc_cell_t cell_o
);
  import fvc_pkg::*;

  logic signed [15:0] tf, ts;
  logic signed [16:0] err_c, abse_c;
  logic signed [16:0] lsum_c;
  logic signed [17:0] lneg_c, absl_c;
  logic signed [13:0] lat_c;
  fvc_cell_t          cell_c;

  logic               s1_valid, s2_valid, s3_valid;
  logic signed [16:0] s1_err;
  logic signed [13:0] s1_lat;
  logic               s1_dead, s2_dead, s3_dead;
  logic signed [15:0] s1_rf, s1_rs, s2_rf, s2_rs, s3_rf;
  fvc_cell_t          s1_cell, s2_cell, s3_cell;

  logic signed [33:0] pf_c, s2_pf;
  logic signed [30:0] pl_c, s2_pl;
  logic signed [21:0] fwd1_c, s3_fwd1;
  logic signed [34:0] pr_c, s3_pr;
  logic signed [17:0] lrnd_c;
  logic signed [18:0] side_c, s3_side;
  logic signed [21:0] fwd2_c, fwd_m_c;
  logic signed [22:0] fwd3_c;
  fvc_cell_t          out_c;

  assign tf = in_data.target_forward;
  assign ts = in_data.target_side;

  always_comb begin
    err_c  = $signed({tf[15], tf}) - $signed({2'b00, cfg.follow_distance});
    abse_c = err_c[16] ? -err_c : err_c;
    lsum_c = $signed({in_data.left_clearance[15], in_data.left_clearance})
           + $signed({in_data.right_clearance[15], in_data.right_clearance});
    lneg_c = -$signed({lsum_c[16], lsum_c});
    absl_c = lneg_c[17] ? -lneg_c : lneg_c;
    // Beyond the cutoff or inside the deadband the lateral term is zero.
    lat_c  = (absl_c[16:0] <= 17'(LAT_CUTOFF) && $unsigned(absl_c) >= LAT_DEADBAND)
             ? lneg_c[13:0] : '0;

    cell_c      = '0;
    cell_c.zero = (tf == '0) && (ts == '0);
    if (tf[15]) begin
      cell_c.x = -$signed({{3{tf[15]}}, tf, 16'b0});
      cell_c.y = -$signed({{3{ts[15]}}, ts, 16'b0});
      cell_c.z = ts[15] ? -PI_Q16 : PI_Q16;
    end else begin
      cell_c.x = $signed({{3{tf[15]}}, tf, 16'b0});
      cell_c.y = $signed({{3{ts[15]}}, ts, 16'b0});
      cell_c.z = '0;
    end
    cell_c.stop = in_data.obstacle_distance < cfg.stop_distance;
    cell_c.slow = in_data.obstacle_distance < cfg.slow_distance;
    cell_c.rem  = in_data.obstacle_distance - cfg.stop_distance;
    cell_c.dvs  = cfg.slow_distance - cfg.stop_distance;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_err  <= err_c;
      s1_lat  <= lat_c;
      s1_dead <= abse_c < $signed(FWD_DEADBAND);
      s1_rf   <= in_data.repel_forward;
      s1_rs   <= in_data.repel_side;
      s1_cell <= cell_c;
    end
  end

  assign pf_c = s1_err * $signed({1'b0, cfg.forward_gain});
  assign pl_c = s1_lat * $signed({1'b0, cfg.lateral_gain});

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pf   <= pf_c;
      s2_pl   <= pl_c;
      s2_dead <= s1_dead;
      s2_rf   <= s1_rf;
      s2_rs   <= s1_rs;
      s2_cell <= s1_cell;
    end
  end

  always_comb begin
    fwd1_c = s2_dead ? '0 : 22'(round_shift(40'(s2_pf), 12));
    pr_c   = fwd1_c * $signed({1'b0, REVERSE_NUM});
    lrnd_c = 18'(round_shift(40'(s2_pl), 12));
    side_c = $signed({lrnd_c[17], lrnd_c}) + $signed({{3{s2_rs[15]}}, s2_rs});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_fwd1 <= fwd1_c;
      s3_pr   <= pr_c;
      s3_side <= side_c;
      s3_dead <= s2_dead;
      s3_rf   <= s2_rf;
      s3_cell <= s2_cell;
    end
  end

  always_comb begin
    fwd2_c = s3_fwd1[21] ? 22'(round_shift(40'(s3_pr), 12)) : s3_fwd1;
    // Outside the deadband the magnitude never drops below the minimum.
    if (s3_dead) begin
      fwd_m_c = '0;
    end else if (fwd2_c < MIN_FWD && fwd2_c > -MIN_FWD) begin
      fwd_m_c = (fwd2_c > 0) ? MIN_FWD : -MIN_FWD;
    end else begin
      fwd_m_c = fwd2_c;
    end
    fwd3_c = $signed({fwd_m_c[21], fwd_m_c}) + $signed({{7{s3_rf[15]}}, s3_rf});
    out_c      = s3_cell;
    out_c.fwd  = fwd3_c;
    out_c.side = s3_side;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_o <= out_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      valid_o  <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      valid_o  <= s3_valid;
    end
  end

endmodule

FILE: rtl/fvc_cell.sv
// One cell of the chain: a CORDIC vectoring step and a restoring divider step, each only where its index is in range.
`timescale 1ns / 1ps
module fvc_cell #(
  parameter int IDX           = 0,
  parameter int CORDIC_STAGES = fvc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_i,
  input  fvc_pkg::fvc_cell_t cell_i,
  output logic               valid_o,
  output fvc_pkg::fvc_cell_t cell_o
);
  import fvc_pkg::*;

  localparam bit ROT_EN = IDX < CORDIC_STAGES;
  localparam bit DIV_EN = IDX < DIV_BITS;

  fvc_cell_t   cell_next;
  logic [15:0] r2;

  always_comb begin
    cell_next = cell_i;
    r2        = {cell_i.rem, 1'b0};
    if (ROT_EN) begin
      if ($signed(cell_i.y) > 0) begin
        cell_next.x = cell_i.x + ($signed(cell_i.y) >>> IDX);
        cell_next.y = cell_i.y - ($signed(cell_i.x) >>> IDX);
        cell_next.z = cell_i.z + atan_entry(IDX);
      end else begin
        cell_next.x = cell_i.x - ($signed(cell_i.y) >>> IDX);
        cell_next.y = cell_i.y + ($signed(cell_i.x) >>> IDX);
        cell_next.z = cell_i.z - atan_entry(IDX);
      end
    end
    if (DIV_EN) begin
      if (r2 >= {1'b0, cell_i.dvs}) begin
        cell_next.rem = 15'(r2 - {1'b0, cell_i.dvs});
        cell_next.quo = {cell_i.quo[DIV_BITS-2:0], 1'b1};
      end else begin
        cell_next.rem = r2[14:0];
        cell_next.quo = {cell_i.quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_o <= cell_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

endmodule

FILE: rtl/fvc_back.sv
// Back stages: turn term, slowdown scaling, obstacle stop, saturation and the output register.
`timescale 1ns / 1ps
module fvc_back #(
  parameter int DATA_WIDTH = fvc_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_i,
  input  fvc_pkg::fvc_cell_t cell_i,
  input  fvc_pkg::fvc_cfg_t  cfg,
  output logic               out_valid,
  output fvc_pkg::fvc_out_t  out_data
);
  import fvc_pkg::*;

  localparam logic signed [39:0] DMAX = 40'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [39:0] DMIN = -DMAX - 40'sd1;

  logic signed [16:0] ang_c, absang_c, turn_in_c;
  logic [12:0]        f_c;
  logic signed [33:0] pt_c, b_pt;
  logic signed [36:0] pfs_c, b_pfs;
  logic signed [22:0] b_fwd;
  logic signed [18:0] b_side;
  logic               b_stop, b_slow, b_valid;
  logic signed [39:0] turn_c, fwd_c;
  fvc_out_t           out_next;

  function automatic logic [15:0] sat(input logic signed [39:0] v, input logic [14:0] bound);
    logic signed [39:0] b;
    logic signed [39:0] t;
    b = $signed(40'({1'b0, bound}));
    if (v > b) begin
      t = b;
    end else if (v < -b) begin
      t = -b;
    end else begin
      t = v;
    end
    if (t > DMAX) begin
      t = DMAX;
    end else if (t < DMIN) begin
      t = DMIN;
    end
    return t[15:0];
  endfunction

  always_comb begin
    ang_c     = cell_i.zero ? '0 : 17'(round_shift(40'(cell_i.z), 4));
    absang_c  = ang_c[16] ? -ang_c : ang_c;
    turn_in_c = (absang_c < $signed(TURN_DEADBAND)) ? '0 : ang_c;
    pt_c      = turn_in_c * $signed({1'b0, cfg.turn_gain});
    // The quotient is always below 1.0, so only the lower clamp can act.
    f_c       = (cell_i.quo < SLOW_MIN) ? {1'b0, SLOW_MIN} : {1'b0, cell_i.quo};
    pfs_c     = cell_i.fwd * $signed({1'b0, f_c});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pt   <= pt_c;
      b_pfs  <= pfs_c;
      b_fwd  <= cell_i.fwd;
      b_side <= cell_i.side;
      b_stop <= cell_i.stop;
      b_slow <= cell_i.slow;
    end
  end

  always_comb begin
    turn_c = round_shift(40'(b_pt), 12);
    fwd_c  = b_slow ? round_shift(40'(b_pfs), 12) : 40'(b_fwd);
    if (b_stop) begin
      out_next = '0;
    end else begin
      out_next.speed_forward = sat(fwd_c, cfg.lin_speed_limit);
      out_next.speed_side    = sat(40'(b_side), cfg.lin_speed_limit);
      out_next.turn_rate     = sat(turn_c, cfg.max_turn_rate);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b_valid   <= valid_i;
      out_valid <= b_valid;
    end
  end

endmodule

FILE: rtl/fvc_checker.sv
// Port-level checks of the controller's handshake behaviour, bound to the top level.
`timescale 1ns / 1ps
module fvc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fvc_pkg::fvc_out_t out_data
);

  // Reset empties the pipeline, so no word is shown just after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word shown after reset");

  // A held output word stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("held output word changed");

  // A stall at the output freezes the pipeline and blocks the input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline is stalled");

  // With the receiver ready the pipeline always moves.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while receiver is ready");

endmodule

bind follow_velocity_controller_core fvc_checker u_fvc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
